// File: sv/sfr_pkg.sv
package sfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CHAN_W     = 11;
    localparam int unsigned NUM_CHAN   = 16;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned POS_W      = 5;
    // Bytes 1 to 23 of a frame: 22 channel bytes and the flag byte.
    localparam int unsigned BODY_BYTES = 23;
    localparam int unsigned BODY_W     = BODY_BYTES * BYTE_W;
    localparam int unsigned CHBITS_W   = NUM_CHAN * CHAN_W;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h0F;
    localparam logic [BYTE_W-1:0] FTR_BYTE  = 8'h00;
    localparam logic [POS_W-1:0]  STORE_LEN = 5'd24;
    localparam logic [BYTE_W-1:0] GAP_RESET = 8'd5;

    // Bit positions inside the flag byte.
    localparam int unsigned FLAG_CH17     = 0;
    localparam int unsigned FLAG_CH18     = 1;
    localparam int unsigned FLAG_LOST     = 2;
    localparam int unsigned FLAG_FAILSAFE = 3;

    localparam logic [IDX_W-1:0] LAST_CHAN = 4'd15;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 48;

endpackage

// File: sv/sbus_frame_receiver.sv
// Channel   Direction  Signals                          Payload
// s_axis    in         s_axis_tvalid/tready/tdata       rx_byte, now_tick
// m_axis    out        m_axis_tvalid/tready/tdata/...   one channel result per transaction
// cfg       in         i_cfg_valid/o_cfg_ready/data     gap_limit
//
// A received byte may be accepted every cycle, except while the footer is held off.
// An accepted frame is copied to a result buffer and sent as sixteen
// transactions, one per cycle while m_axis_tready is high.
// The footer byte of a new frame is held off while the buffer still sends.
// Reset is synchronous and active low; gap_limit returns to 5.
module sbus_frame_receiver
    import sfr_pkg::*;
#(
    parameter int unsigned TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] rx_byte, [39:8] now_tick
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [10:0] channel_value, [11] digital_ch17, [12] digital_ch18,
    // [13] lost_flag, [14] failsafe_flag, [46:15] frame_time, [47] zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [3:0] channel_index
    output logic [IDX_W-1:0]      m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [BYTE_W-1:0]     i_cfg_data
);

    logic [BYTE_W-1:0]     r_gap;
    logic                  r_rx;
    logic [POS_W-1:0]      r_pos;
    logic [TICK_WIDTH-1:0] r_last;
    logic [BODY_W-1:0]     r_body;

    logic                  r_busy;
    logic [IDX_W-1:0]      r_cnt;
    logic [CHBITS_W-1:0]   r_chan;
    logic [3:0]            r_flags;
    logic [TIME_W-1:0]     r_time;

    logic [BYTE_W-1:0]     w_byte;
    logic [TIME_W-1:0]     w_raw;
    logic [TICK_WIDTH-1:0] w_now;
    logic [TICK_WIDTH-1:0] w_diff;
    logic                  w_gap_hit;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_at_footer;
    logic                  w_frame_ok;

    assign w_byte = s_axis_tdata[BYTE_W-1:0];
    assign w_raw  = s_axis_tdata[BYTE_W +: TIME_W];
    assign w_now  = TICK_WIDTH'(w_raw);
    assign w_diff = w_now - r_last;
    assign w_gap_hit = (w_diff > TICK_WIDTH'(r_gap));

    assign w_at_footer = r_rx && (r_pos >= STORE_LEN);
    assign s_axis_tready = !(r_busy && w_at_footer);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = r_busy && m_axis_tready;
    assign w_frame_ok = w_in_acc && !w_gap_hit && w_at_footer && (w_byte == FTR_BYTE);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_valid) begin
            r_gap <= i_cfg_data;
        end
    end

    // Reassembly state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx   <= 1'b0;
            r_pos  <= '0;
            r_last <= '0;
        end else if (w_in_acc) begin
            r_last <= w_now;
            if (w_gap_hit || !r_rx) begin
                if (w_byte == HDR_BYTE) begin
                    r_rx  <= 1'b1;
                    r_pos <= POS_W'(1);
                end else begin
                    r_rx  <= 1'b0;
                    r_pos <= '0;
                end
            end else if (!w_at_footer) begin
                r_pos <= r_pos + POS_W'(1);
            end else begin
                r_rx  <= 1'b0;
                r_pos <= '0;
            end
        end
    end

    // Body bytes shift in from the top, so byte 1 ends up in the lowest bits.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_rx && !w_gap_hit && !w_at_footer) begin
            r_body <= {w_byte, r_body[BODY_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_frame_ok) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_out_acc) begin
            if (r_cnt == LAST_CHAN) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // The channel bits move down by one channel per transaction.
    always_ff @(posedge i_clk) begin
        if (w_frame_ok) begin
            r_chan  <= r_body[CHBITS_W-1:0];
            r_flags <= r_body[BODY_W-BYTE_W +: 4];
            r_time  <= w_raw;
        end else if (w_out_acc) begin
            r_chan <= {{CHAN_W{1'b0}}, r_chan[CHBITS_W-1:CHAN_W]};
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tuser  = r_cnt;
    assign m_axis_tlast  = (r_cnt == LAST_CHAN);
    assign m_axis_tdata  = {1'b0, r_time,
                            r_flags[FLAG_FAILSAFE], r_flags[FLAG_LOST],
                            r_flags[FLAG_CH18], r_flags[FLAG_CH17],
                            r_chan[CHAN_W-1:0]};

endmodule
